>>> rtl/rdwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_pkg
// Types, codes and seed constants shared by the dual-word checksum block.
// ----------------------------------------------------------------------------
package rdwc_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_DATA   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    // lookup table depth; the position counter and table index wrap at it
    localparam int LOOKUP_WORDS = 64;

    localparam logic [3:0] VARIANT_RESET  = 4'd2;
    localparam logic [3:0] VARIANT_ADD    = 4'd3;
    localparam logic [3:0] VARIANT_LOOKUP = 4'd5;
    localparam logic [3:0] VARIANT_MUL    = 4'd6;

    localparam logic [31:0] SEED_STD    = 32'hF8CA4DDC;
    localparam logic [31:0] SEED_ADD    = 32'hA3886759;
    localparam logic [31:0] SEED_LOOKUP = 32'hDF26F436;
    localparam logic [31:0] SEED_MUL    = 32'h1FEA617A;
    localparam logic [4:0]  ROT_MASK    = 5'h1F;

    typedef struct packed {
        logic [31:0] plain_sum;
        logic [31:0] carry_count;
        logic [31:0] xor_acc;
        logic [31:0] rotated_sum;
        logic [31:0] compare_mix;
        logic [31:0] mixed_sum;
    } t_acc_set;

    function automatic logic [31:0] seed_for(input logic [3:0] variant);
        logic [31:0] s;
        case (variant)
            4'd1, 4'd2, 4'd7, 4'd8, 4'd9: s = SEED_STD;
            VARIANT_ADD:                  s = SEED_ADD;
            VARIANT_LOOKUP:               s = SEED_LOOKUP;
            VARIANT_MUL:                  s = SEED_MUL;
            default:                      s = 32'd0;
        endcase
        return s;
    endfunction

    // rotate left; a zero amount returns the word as it is
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

endpackage

>>> rtl/rdwc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_if
// Valid/ready channels: image items in, checksum results out.
// ----------------------------------------------------------------------------
interface rdwc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] word;
    logic [5:0]  table_index;
    logic        last;

    modport source (output valid, opcode, word, table_index, last, input ready);
    modport sink   (input valid, opcode, word, table_index, last, output ready);
endinterface

interface rdwc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum_high;
    logic [31:0] checksum_low;

    modport source (output valid, checksum_high, checksum_low, input ready);
    modport sink   (input valid, checksum_high, checksum_low, output ready);
endinterface

>>> rtl/rdwc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rdwc_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_combine
// Folds a snapshot of the six accumulators into the two checksum words.
// ----------------------------------------------------------------------------
module rdwc_combine
    import rdwc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [3:0]   i_variant,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_acc_set     i_acc,
    rdwc_result_if.source o_result
);

    logic        r_mid_valid;
    logic [31:0] r_t_hi, r_c_hi, r_t_lo, r_c_lo;
    logic        r_out_valid;
    logic [31:0] r_out_hi, r_out_lo;
    logic        out_load, mid_load;
    logic        is_mul, is_sum;
    logic [31:0] n_t_hi, n_t_lo, n_out_hi, n_out_lo;

    assign is_mul = (i_variant == VARIANT_MUL);
    assign is_sum = (i_variant == VARIANT_ADD) || is_mul;

    assign out_load = !r_out_valid || o_result.ready;
    assign mid_load = !r_mid_valid || out_load;
    assign o_ready  = mid_load;

    // first term: product for the multiply rule, xor otherwise
    always_comb begin
        if (is_mul) begin
            n_t_hi = i_acc.plain_sum * i_acc.carry_count;
            n_t_lo = i_acc.rotated_sum * i_acc.compare_mix;
        end else begin
            n_t_hi = i_acc.plain_sum ^ i_acc.carry_count;
            n_t_lo = i_acc.rotated_sum ^ i_acc.compare_mix;
        end
    end

    always_comb begin
        if (is_sum) begin
            n_out_hi = r_t_hi + r_c_hi;
            n_out_lo = r_t_lo + r_c_lo;
        end else begin
            n_out_hi = r_t_hi ^ r_c_hi;
            n_out_lo = r_t_lo ^ r_c_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mid_load) begin
                r_mid_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_load && i_valid) begin
            r_t_hi <= n_t_hi;
            r_c_hi <= i_acc.xor_acc;
            r_t_lo <= n_t_lo;
            r_c_lo <= i_acc.mixed_sum;
        end
        if (out_load && r_mid_valid) begin
            r_out_hi <= n_out_hi;
            r_out_lo <= n_out_lo;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.checksum_high = r_out_hi;
    assign o_result.checksum_low  = r_out_lo;

endmodule

>>> rtl/rom_dual_word_checksum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_dual_word_checksum_top
// Dual-word image checksum: six seeded accumulators, optional lookup mixing,
// and a per-variant combine into two checksum words on the closing word.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake       Payload
//  i_item    in   valid / ready   opcode, word, table_index, last
//  o_result  out  valid / ready   checksum_high, checksum_low
//  cfg       in   i_cfg_we        i_cfg_wdata (variant)
//
//  One item is accepted per cycle unless the input stage stalls. A closing
//  data word reaches o_result through the input stage, snapshot, product
//  stage and output register; the product stage does the multiply variant's 32x32 multiply.
//  Lookup words are written to the table RAM on their accept edge and read
//  with the position of the data word at its accept edge.
//  Synchronous active-low reset clears the valids, the counters and the
//  accumulators; the table RAM is not cleared. A stalled result holds; the
//  snapshot and product stages take two more closing words, and a further
//  closing word then waits at the input stage and stalls the input.
// ----------------------------------------------------------------------------
module rom_dual_word_checksum_top
    import rdwc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    rdwc_item_if.sink     i_item,
    rdwc_result_if.source o_result
);

    localparam int AW = $clog2(LOOKUP_WORDS);

    // configuration
    logic [3:0]    r_variant;

    // accept-side position counter
    logic [AW-1:0] r_word_pos;
    logic          accept;
    t_opcode       in_op;

    // input stage
    logic          r_s1_valid;
    t_opcode       r_s1_op;
    logic [31:0]   r_s1_word;
    logic          r_s1_last;
    logic [31:0]   lookup_word;
    logic          s1_result, s1_go;

    // accumulators and their next values
    t_acc_set      r_acc, n_acc;
    logic [32:0]   sum33;
    logic [31:0]   rot, mix_term;

    // snapshot stage toward the combine unit
    logic          r_snap_valid;
    t_acc_set      r_snap;
    logic          snap_load, comb_ready;

    assign in_op  = t_opcode'(i_item.opcode);
    assign accept = i_item.valid && i_item.ready;

    // Take a new item whenever the input stage is empty or moves on.
    assign s1_result    = r_s1_valid && (r_s1_op == OP_DATA) && r_s1_last;
    assign s1_go        = r_s1_valid && (!s1_result || snap_load);
    assign i_item.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= VARIANT_RESET;
        end else if (i_cfg_we) begin
            r_variant <= i_cfg_wdata;
        end
    end

    // Track the position each data word will use, in accept order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos <= '0;
        end else if (accept) begin
            case (in_op)
                OP_START: r_word_pos <= '0;
                OP_DATA:  r_word_pos <= r_word_pos + 1'b1;
                default:  r_word_pos <= r_word_pos;
            endcase
        end
    end

    // Lookup table: write on load accept, read on data accept.
    rdwc_ram #(
        .WIDTH (32),
        .DEPTH (LOOKUP_WORDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && (in_op == OP_LOAD)),
        .i_waddr (i_item.table_index[AW-1:0]),
        .i_wdata (i_item.word),
        .i_re    (accept && (in_op == OP_DATA)),
        .i_raddr (r_word_pos),
        .o_rdata (lookup_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= in_op;
            r_s1_word <= i_item.word;
            r_s1_last <= i_item.last;
        end
    end

    // Per-word update of all six accumulators.
    always_comb begin
        sum33    = {1'b0, r_acc.plain_sum} + {1'b0, r_s1_word};
        rot      = rotl32(r_s1_word, r_s1_word[4:0] & ROT_MASK);
        n_acc    = r_acc;
        mix_term = '0;
        case (r_s1_op)
            OP_START: begin
                n_acc.plain_sum   = seed_for(r_variant);
                n_acc.carry_count = seed_for(r_variant);
                n_acc.xor_acc     = seed_for(r_variant);
                n_acc.rotated_sum = seed_for(r_variant);
                n_acc.compare_mix = seed_for(r_variant);
                n_acc.mixed_sum   = seed_for(r_variant);
            end
            OP_DATA: begin
                n_acc.plain_sum   = sum33[31:0];
                n_acc.carry_count = r_acc.carry_count + {31'd0, sum33[32]};
                n_acc.xor_acc     = r_acc.xor_acc ^ r_s1_word;
                n_acc.rotated_sum = r_acc.rotated_sum + rot;
                if (r_acc.compare_mix < r_s1_word) begin
                    n_acc.compare_mix = r_acc.compare_mix ^ sum33[31:0] ^ r_s1_word;
                end else begin
                    n_acc.compare_mix = r_acc.compare_mix ^ rot;
                end
                // mix against the table entry or the fresh rotated sum
                if (r_variant == VARIANT_LOOKUP) begin
                    mix_term = lookup_word;
                end else begin
                    mix_term = n_acc.rotated_sum;
                end
                n_acc.mixed_sum = r_acc.mixed_sum + (r_s1_word ^ mix_term);
            end
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (s1_go) begin
            r_acc <= n_acc;
        end
    end

    // Hold a copy of the closing state so later words can keep accumulating.
    assign snap_load = !r_snap_valid || comb_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_load) begin
            r_snap_valid <= s1_go && s1_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_load && s1_go && s1_result) begin
            r_snap <= n_acc;
        end
    end

    rdwc_combine u_combine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_variant (r_variant),
        .i_valid   (r_snap_valid),
        .o_ready   (comb_ready),
        .i_acc     (r_snap),
        .o_result  (o_result)
    );

endmodule

>>> rtl/rdwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_checker
// Port-level checks on the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
module rdwc_checker
    import rdwc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_opcode,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_high,
    input logic [31:0] i_out_low
);

    logic [2:0] r_pending;
    logic       res_in, res_out;

    assign res_in  = i_in_valid && i_in_ready && (i_in_opcode == OP_DATA) && i_in_last;
    assign res_out = i_out_valid && i_out_ready;

    // count closing words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {2'd0, res_in} - {2'd0, res_out};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_high) && $stable(i_out_low))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 3'd0)
        else $error("result without a closing word");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd4)
        else $error("more closing words in flight than stages");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_pending == 3'd0 |-> i_in_ready)
        else $error("input stalled with no result in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind rom_dual_word_checksum_top rdwc_checker u_rdwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_opcode (i_item.opcode),
    .i_in_last   (i_item.last),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_high  (o_result.checksum_high),
    .i_out_low   (o_result.checksum_low)
);
